### src/snm_pkg.sv
package snm_pkg;

   localparam int SLOT_W      = 6;
   localparam int DATA_W      = 16;
   localparam int PROD_W      = 2 * DATA_W;
   localparam int ACC_W       = 40;
   localparam int CSR_IDX_W   = 2;
   localparam int SIG_ENTRIES = 256;
   localparam int SIG_IDX_W   = $clog2(SIG_ENTRIES);
   // the sigmoid window [-8, 8) in Q8.24 spans 2^28
   localparam int SPAN_W      = 28;

   localparam logic FUNC_WEIGHT = 1'b0;
   localparam logic FUNC_VALUE  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_THR = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_THR  = CSR_IDX_W'(1);

   localparam logic [DATA_W-1:0] HIGH_THR_RESET = 16'd58982;
   localparam logic [DATA_W-1:0] LOW_THR_RESET  = 16'd6554;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] EIGHT_Q24 = ACC_W'(134217728);
   localparam logic signed [ACC_W-1:0] NEG_EIGHT_Q24 = -EIGHT_Q24;

   localparam logic [63:0] ONE_Q32   = 64'h0000_0001_0000_0000;
   localparam logic [63:0] INV_E_Q32 = 64'd1580030169;

   typedef enum logic [1:0] {
      DEC_LOW       = 2'd0,
      DEC_HIGH      = 2'd1,
      DEC_UNDECIDED = 2'd2
   } decision_type;

   typedef struct packed {
      logic                     last;
      logic                     in_range;
      logic signed [DATA_W-1:0] operand;
   } mac_op_type;

   typedef struct packed {
      logic                    valid;
      logic signed [ACC_W-1:0] sum;
   } sum_xfer_type;

   typedef logic [SIG_ENTRIES-1:0][DATA_W-1:0] sig_table_type;

   // restoring long division, only used while building the constant table
   function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] dvs);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, dvs}) begin
            rem    = rem - {1'b0, dvs};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // e^-f for f in [0,1), Q32 in and out, taylor series
   function automatic logic [63:0] exp_neg_frac(logic [63:0] f);
      logic [63:0] term;
      logic [63:0] acc;
      term = ONE_Q32;
      acc  = ONE_Q32;
      for (int k = 1; k <= 20; k++) begin
         term = udiv64((term * f) >> 32, 64'(k));
         if (k[0]) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      return acc;
   endfunction

   function automatic sig_table_type build_sig_table();
      sig_table_type tbl;
      logic [63:0]   n;
      logic [63:0]   twice;
      logic [63:0]   d;
      logic [63:0]   t;
      logic [63:0]   whole;
      logic [63:0]   e;
      logic [63:0]   den;
      logic [63:0]   s;
      logic          pos;
      n = 64'(SIG_ENTRIES);
      for (int i = 0; i < SIG_ENTRIES; i++) begin
         twice = 64'(2 * i + 1);
         pos   = twice > n;
         d     = pos ? twice - n : n - twice;
         t     = udiv64(d << 35, n);
         whole = t >> 32;
         e     = exp_neg_frac({32'd0, t[31:0]});
         for (int w = 0; w < 8; w++) begin
            if (64'(w) < whole) begin
               e = (e * INV_E_Q32) >> 32;
            end
         end
         den = ONE_Q32 + e;
         if (pos) begin
            s = udiv64((64'd1 << 48) + (den >> 1), den);
         end else begin
            s = udiv64((e << 16) + (den >> 1), den);
         end
         if (s > 64'd65535) begin
            s = 64'd65535;
         end
         tbl[i] = s[DATA_W-1:0];
      end
      return tbl;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

endpackage

### src/snm_req_if.sv
interface snm_req_if;
   logic                             valid;
   logic                             ready;
   logic                             func;
   logic [snm_pkg::SLOT_W-1:0]       slot;
   logic signed [snm_pkg::DATA_W-1:0] operand;
   logic                             last;

   modport source (output valid, output func, output slot, output operand, output last,
                   input ready);
   modport sink (input valid, input func, input slot, input operand, input last,
                 output ready);
endinterface

### src/snm_rsp_if.sv
interface snm_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [snm_pkg::DATA_W-1:0] activation;
   snm_pkg::decision_type     decision;

   modport source (output valid, output activation, output decision, input ready);
   modport sink (input valid, input activation, input decision, output ready);
endinterface

### src/snm_weight_ram.sv
module snm_weight_ram #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [snm_pkg::DATA_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [snm_pkg::DATA_W-1:0] rd_data
);

   logic [snm_pkg::DATA_W-1:0] mem_ff [DEPTH];
   logic [snm_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/snm_mac.sv
module snm_mac (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  snm_pkg::mac_op_type        in_op,
   input  logic [snm_pkg::DATA_W-1:0] weight,
   output logic                       in_ready,
   output snm_pkg::sum_xfer_type      sum_out,
   input  logic                       sum_ready
);

   logic                                v1_ff;
   logic                                v1_in;
   snm_pkg::mac_op_type                 op1_ff;
   logic                                v2_ff;
   logic                                v2_in;
   logic                                last2_ff;
   logic signed [snm_pkg::PROD_W-1:0]   prod2_ff;
   logic signed [snm_pkg::ACC_W-1:0]    acc_ff;
   logic signed [snm_pkg::ACC_W-1:0]    acc_in;
   logic signed [snm_pkg::DATA_W-1:0]   weight_eff;
   logic signed [snm_pkg::ACC_W:0]      sum_wide;
   logic signed [snm_pkg::ACC_W-1:0]    sum_sat;
   logic                                s1_free;
   logic                                s2_free;
   logic                                s2_go;

   assign s2_go   = v2_ff && (!last2_ff || sum_ready);
   assign s2_free = !v2_ff || s2_go;
   assign s1_free = !v1_ff || s2_free;
   assign in_ready = s1_free;

   // out-of-range slots act as weight zero
   assign weight_eff = op1_ff.in_range ? $signed(weight) : '0;

   always_comb begin
      sum_wide = (snm_pkg::ACC_W + 1)'(acc_ff) + (snm_pkg::ACC_W + 1)'(prod2_ff);
      if (sum_wide[snm_pkg::ACC_W] != sum_wide[snm_pkg::ACC_W-1]) begin
         sum_sat = sum_wide[snm_pkg::ACC_W] ? snm_pkg::ACC_MIN : snm_pkg::ACC_MAX;
      end else begin
         sum_sat = sum_wide[snm_pkg::ACC_W-1:0];
      end
   end

   always_comb begin
      v1_in  = s1_free ? in_valid : v1_ff;
      v2_in  = s2_free ? v1_ff : v2_ff;
      acc_in = acc_ff;
      if (s2_go) begin
         acc_in = last2_ff ? '0 : sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         acc_ff <= '0;
      end else begin
         v1_ff  <= v1_in;
         v2_ff  <= v2_in;
         acc_ff <= acc_in;
      end
      if (s1_free) begin
         op1_ff <= in_op;
      end
      if (s2_free) begin
         prod2_ff <= op1_ff.operand * weight_eff;
         last2_ff <= op1_ff.last;
      end
   end

   assign sum_out.valid = v2_ff && last2_ff;
   assign sum_out.sum   = sum_sat;

endmodule

### src/snm_act.sv
module snm_act (
   input  logic                       clock,
   input  logic                       reset,
   input  snm_pkg::sum_xfer_type      sum_in,
   output logic                       sum_ready,
   input  logic [snm_pkg::DATA_W-1:0] high_thr,
   input  logic [snm_pkg::DATA_W-1:0] low_thr,
   snm_rsp_if.source                  rsp
);

   localparam int SCALED_W = snm_pkg::SPAN_W + snm_pkg::SIG_IDX_W;

   logic                              va_ff;
   logic                              va_in;
   logic signed [snm_pkg::ACC_W-1:0]  sum_a_ff;
   logic                              vb_ff;
   logic                              vb_in;
   logic [snm_pkg::DATA_W-1:0]        act_b_ff;
   logic                              vo_ff;
   logic                              vo_in;
   logic [snm_pkg::DATA_W-1:0]        act_o_ff;
   snm_pkg::decision_type             dec_o_ff;
   snm_pkg::decision_type             dec_in;
   logic                              a_free;
   logic                              b_free;
   logic                              out_free;
   logic [snm_pkg::SPAN_W-1:0]        offset;
   logic [SCALED_W-1:0]               scaled;
   logic [snm_pkg::SIG_IDX_W-1:0]     idx;

   assign out_free  = !vo_ff || rsp.ready;
   assign b_free    = !vb_ff || out_free;
   assign a_free    = !va_ff || b_free;
   assign sum_ready = a_free;

   // table index, saturating outside plus or minus 8
   always_comb begin
      offset = sum_a_ff[snm_pkg::SPAN_W-1:0] + snm_pkg::EIGHT_Q24[snm_pkg::SPAN_W-1:0];
      scaled = SCALED_W'(offset) * SCALED_W'(snm_pkg::SIG_ENTRIES);
      if (sum_a_ff < snm_pkg::NEG_EIGHT_Q24) begin
         idx = '0;
      end else if (sum_a_ff >= snm_pkg::EIGHT_Q24) begin
         idx = snm_pkg::SIG_IDX_W'(snm_pkg::SIG_ENTRIES - 1);
      end else begin
         idx = scaled[snm_pkg::SPAN_W +: snm_pkg::SIG_IDX_W];
      end
   end

   // high is checked first so it wins with overlapping thresholds
   always_comb begin
      if (act_b_ff > high_thr) begin
         dec_in = snm_pkg::DEC_HIGH;
      end else if (act_b_ff < low_thr) begin
         dec_in = snm_pkg::DEC_LOW;
      end else begin
         dec_in = snm_pkg::DEC_UNDECIDED;
      end
   end

   always_comb begin
      va_in = a_free ? sum_in.valid : va_ff;
      vb_in = b_free ? va_ff : vb_ff;
      vo_in = out_free ? vb_ff : vo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
         vo_ff <= vo_in;
      end
      if (a_free) begin
         sum_a_ff <= sum_in.sum;
      end
      if (b_free) begin
         act_b_ff <= snm_pkg::SIG_TABLE[idx];
      end
      if (out_free) begin
         act_o_ff <= act_b_ff;
         dec_o_ff <= dec_in;
      end
   end

   assign rsp.valid      = vo_ff;
   assign rsp.activation = act_o_ff;
   assign rsp.decision   = dec_o_ff;

endmodule

### src/sigmoid_neuron_mac.sv
// Single sigmoid neuron. A request with func 0 writes a Q4.12 weight into the slot's
// entry of the weight RAM; a request with func 1 multiplies its Q4.12 value by that
// slot's weight and adds it into a saturating 40-bit Q16.24 accumulator. The value
// request marked last produces one response: the 256-entry sigmoid table output in
// Q0.16 (saturating outside plus or minus 8) and a low/high/undecided class against the
// two threshold registers; the accumulator then clears. Slots at or above MAX_INPUTS
// read as weight zero and ignore writes. One request is accepted every cycle when not
// stalled: the weight RAM does one write or one read per cycle and the weight read,
// multiply, accumulate, table lookup and classify each take a pipeline register, in
// that order, on the way to the response. Requests stall only when the response
// register is held and every stage behind it is full. Weights read before they are
// written are undefined. Thresholds may be written only while no request is in flight.
module sigmoid_neuron_mac #(
   parameter int MAX_INPUTS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   snm_req_if.sink                       req_ch,
   snm_rsp_if.source                     rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [snm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [snm_pkg::DATA_W-1:0]    csr_wdata
);

   localparam int ADDR_W = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
   localparam int EXT_W  = snm_pkg::SLOT_W + ADDR_W;

   logic                       accept;
   logic                       is_value;
   logic [EXT_W-1:0]           slot_ext;
   logic                       in_range;
   logic [ADDR_W-1:0]          addr;
   logic [snm_pkg::DATA_W-1:0] rd_data;
   logic                       mac_ready;
   snm_pkg::mac_op_type        mac_op;
   snm_pkg::sum_xfer_type      sum_xfer;
   logic                       sum_ready;
   logic [snm_pkg::DATA_W-1:0] high_thr_ff;
   logic [snm_pkg::DATA_W-1:0] high_thr_in;
   logic [snm_pkg::DATA_W-1:0] low_thr_ff;
   logic [snm_pkg::DATA_W-1:0] low_thr_in;

   assign accept   = req_ch.valid && req_ch.ready;
   assign is_value = req_ch.func == snm_pkg::FUNC_VALUE;
   assign slot_ext = EXT_W'(req_ch.slot);
   assign in_range = slot_ext < EXT_W'(MAX_INPUTS);
   assign addr     = slot_ext[ADDR_W-1:0];
   assign req_ch.ready = mac_ready;

   assign mac_op.last     = req_ch.last;
   assign mac_op.in_range = in_range;
   assign mac_op.operand  = req_ch.operand;

   snm_weight_ram #(
      .DEPTH  (MAX_INPUTS),
      .ADDR_W (ADDR_W)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (accept && !is_value && in_range),
      .wr_addr (addr),
      .wr_data (req_ch.operand),
      .rd_en   (accept && is_value),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   snm_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept && is_value),
      .in_op     (mac_op),
      .weight    (rd_data),
      .in_ready  (mac_ready),
      .sum_out   (sum_xfer),
      .sum_ready (sum_ready)
   );

   snm_act u_act (
      .clock     (clock),
      .reset     (reset),
      .sum_in    (sum_xfer),
      .sum_ready (sum_ready),
      .high_thr  (high_thr_ff),
      .low_thr   (low_thr_ff),
      .rsp       (rsp_ch)
   );

   always_comb begin
      high_thr_in = high_thr_ff;
      low_thr_in  = low_thr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            snm_pkg::CSR_HIGH_THR: high_thr_in = csr_wdata;
            snm_pkg::CSR_LOW_THR:  low_thr_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_thr_ff <= snm_pkg::HIGH_THR_RESET;
         low_thr_ff  <= snm_pkg::LOW_THR_RESET;
      end else begin
         high_thr_ff <= high_thr_in;
         low_thr_ff  <= low_thr_in;
      end
   end

`ifndef SYNTH
   // backpressure only reaches the request side from a blocked response
   a_stall_from_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (rsp_ch.valid && !rsp_ch.ready))
      else $error("request stalled while response side is free");

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("response valid right after reset");
`endif

endmodule

### bench/neuron_result_checker.sv
`timescale 1ns / 100ps

module neuron_result_checker
   import snm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   snm_req_if                   req_mon,
   snm_rsp_if                   rsp_mon,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata,
   output int                   outstanding,
   output int                   mismatches
);

   localparam int                      N_SLOTS   = 64;
   localparam logic [63:0]             Q32_ONE   = 64'h1_0000_0000;
   localparam logic [63:0]             Q32_INV_E = 64'd1580030169;
   localparam logic signed [ACC_W+1:0] SUM_CEIL  = 42'sd549755813887;
   localparam logic signed [ACC_W+1:0] SUM_FLOOR = -42'sd549755813888;
   // plus or minus 8 in Q8.24
   localparam logic signed [ACC_W+1:0] WINDOW    = 42'sd134217728;

   typedef struct packed {
      logic [DATA_W-1:0] activation;
      decision_type      decision;
   } neuron_result_t;

   neuron_result_t           expected_results[$];
   logic [DATA_W-1:0]        sigmoid_lut[SIG_ENTRIES];
   logic signed [DATA_W-1:0] weights[N_SLOTS];
   logic signed [ACC_W-1:0]  acc_sum;
   logic [DATA_W-1:0]        thr_high;
   logic [DATA_W-1:0]        thr_low;
   int                       mismatch_count;

   // e^-x for x in [0,1), q32 fixed point
   function automatic logic [63:0] exp_neg_q32(logic [63:0] x);
      logic [63:0] term;
      logic [63:0] total;
      term  = Q32_ONE;
      total = Q32_ONE;
      for (int k = 1; k <= 20; k++) begin
         term = ((term * x) >> 32) / 64'(k);
         if (k % 2 == 1) begin
            total = total - term;
         end else begin
            total = total + term;
         end
      end
      return total;
   endfunction

   function automatic logic [DATA_W-1:0] sigmoid_point(int i);
      logic [63:0] n;
      logic [63:0] odd;
      logic [63:0] gap;
      logic [63:0] mag;
      logic [63:0] e;
      logic [63:0] den;
      logic [63:0] q;
      logic        positive;
      n        = 64'(SIG_ENTRIES);
      odd      = 64'(2 * i + 1);
      positive = odd > n;
      gap      = positive ? odd - n : n - odd;
      mag      = (gap << 35) / n;
      e        = exp_neg_q32({32'd0, mag[31:0]});
      // whole units of |x| each scale by 1/e
      for (int u = 0; u < int'(mag >> 32); u++) begin
         e = (e * Q32_INV_E) >> 32;
      end
      den = Q32_ONE + e;
      if (positive) begin
         q = ((64'd1 << 48) + (den >> 1)) / den;
      end else begin
         q = ((e << 16) + (den >> 1)) / den;
      end
      if (q > 64'd65535) begin
         q = 64'd65535;
      end
      return q[DATA_W-1:0];
   endfunction

   function automatic neuron_result_t classify(logic signed [ACC_W+1:0] total);
      neuron_result_t r;
      int             idx;
      logic [63:0]    offset;
      if (total < -WINDOW) begin
         idx = 0;
      end else if (total >= WINDOW) begin
         idx = SIG_ENTRIES - 1;
      end else begin
         offset = 64'(total + WINDOW);
         idx    = int'((offset * 64'(SIG_ENTRIES)) >> 28);
      end
      if (idx > SIG_ENTRIES - 1) begin
         idx = SIG_ENTRIES - 1;
      end
      r.activation = sigmoid_lut[idx];
      // high wins when thresholds overlap
      if (r.activation > thr_high) begin
         r.decision = DEC_HIGH;
      end else if (r.activation < thr_low) begin
         r.decision = DEC_LOW;
      end else begin
         r.decision = DEC_UNDECIDED;
      end
      return r;
   endfunction

   initial begin
      for (int i = 0; i < SIG_ENTRIES; i++) begin
         sigmoid_lut[i] = sigmoid_point(i);
      end
   end

   always @(posedge clock) begin
      logic signed [2*DATA_W-1:0] product;
      logic signed [ACC_W+1:0]    total;
      neuron_result_t             want;
      if (reset) begin
         expected_results.delete();
         acc_sum  = '0;
         thr_high = 16'd58982;
         thr_low  = 16'd6554;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_HIGH_THR: thr_high = csr_wdata;
               CSR_LOW_THR:  thr_low  = csr_wdata;
               default:      ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.func == FUNC_WEIGHT) begin
               weights[req_mon.slot] = req_mon.operand;
            end else begin
               product = weights[req_mon.slot] * req_mon.operand;
               total   = acc_sum + product;
               if (total > SUM_CEIL) begin
                  total = SUM_CEIL;
               end else if (total < SUM_FLOOR) begin
                  total = SUM_FLOOR;
               end
               acc_sum = total[ACC_W-1:0];
               if (req_mon.last) begin
                  expected_results = {expected_results, classify(total)};
                  acc_sum = '0;
               end
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected response: expected none, got activation %0d decision %0d",
                        $time, rsp_mon.activation, rsp_mon.decision);
            end else begin
               want = expected_results.pop_front();
               if (rsp_mon.activation !== want.activation) begin
                  mismatch_count++;
                  $display("%0t: activation mismatch: expected %0d, got %0d",
                           $time, want.activation, rsp_mon.activation);
               end
               if (rsp_mon.decision !== want.decision) begin
                  mismatch_count++;
                  $display("%0t: decision mismatch: expected %0d, got %0d",
                           $time, want.decision, rsp_mon.decision);
               end
            end
         end
      end
      outstanding <= expected_results.size();
      mismatches  <= mismatch_count;
   end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import snm_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = CSR_IDX_W'(3);

   localparam int N_SLOTS          = 64;
   localparam int N_PHASES         = 6;
   localparam int RANDOM_PER_PHASE = 12;
   localparam int CALM_ITEMS       = 8;
   localparam int LONG_HOLD        = 200;
   localparam int HOLD_BURST       = 10;
   localparam int SETTLE_CYCLES    = 10;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int SAT_CLIMB        = 520;
   localparam int SAT_RETURN       = 512;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0]    csr_wdata;
   logic                 calm = 1'b0;
   logic                 long_hold_req = 1'b0;
   int                   outstanding;
   int                   mismatches;
   int                   cycle_count;
   int                   accepted;
   logic [N_SLOTS-1:0]   slot_written;
   logic [SLOT_W-1:0]    written_slots[$];

   snm_req_if req_ch();
   snm_rsp_if rsp_ch();

   sigmoid_neuron_mac dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   neuron_result_checker result_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin : rsp_ready_driver
      logic hold_done;
      hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold_req && !hold_done) begin
            // long back-pressure so the pipeline fills and the request side stalls
            hold_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic logic [DATA_W-1:0] rand_operand();
      case ($urandom_range(0, 3))
         0:       return DATA_W'($urandom);
         1:       return DATA_W'($urandom_range(0, 16383)) - 16'd8192;
         2:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         default: return DATA_W'($urandom_range(0, 2047)) - 16'd1024;
      endcase
   endfunction

   // only slots that already hold a weight are ever read
   function automatic logic [SLOT_W-1:0] pick_slot();
      return written_slots[$urandom_range(0, written_slots.size() - 1)];
   endfunction

   task automatic send_request(input logic func, input logic [SLOT_W-1:0] slot,
                               input logic [DATA_W-1:0] operand, input logic last);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.func    <= func;
      req_ch.slot    <= slot;
      req_ch.operand <= operand;
      req_ch.last    <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      accepted++;
   endtask

   task automatic put_weight(input logic [SLOT_W-1:0] slot, input logic [DATA_W-1:0] w,
                             input logic last);
      send_request(FUNC_WEIGHT, slot, w, last);
      if (!slot_written[slot]) begin
         slot_written[slot] = 1'b1;
         written_slots = {written_slots, slot};
      end
   endtask

   task automatic put_value(input logic [SLOT_W-1:0] slot, input logic [DATA_W-1:0] v,
                            input logic last);
      send_request(FUNC_VALUE, slot, v, last);
   endtask

   task automatic random_weight();
      logic [DATA_W-1:0] w;
      // zero weight disconnects the slot
      w = ($urandom_range(0, 7) == 0) ? '0 : rand_operand();
      put_weight(SLOT_W'($urandom_range(0, N_SLOTS - 1)), w, $urandom_range(0, 3) == 0);
   endtask

   task automatic run_evaluation();
      int   n_values;
      logic drop_last;
      n_values  = $urandom_range(1, 12);
      // an unterminated sequence carries its sum into the next one
      drop_last = ($urandom_range(0, 9) == 0);
      repeat ($urandom_range(0, 3)) random_weight();
      for (int i = 0; i < n_values; i++) begin
         if ($urandom_range(0, 15) == 0) begin
            random_weight();
         end
         put_value(pick_slot(), rand_operand(), (i == n_values - 1) && !drop_last);
      end
   endtask

   // every request makes a response while the response side is held off
   task automatic hold_burst();
      long_hold_req <= 1'b1;
      repeat (SETTLE_CYCLES) @(posedge clock);
      repeat (HOLD_BURST) put_value(pick_slot(), rand_operand(), 1'b1);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_thresholds(input logic [DATA_W-1:0] hi, input logic [DATA_W-1:0] lo);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_HIGH_THR;
      csr_wdata <= hi;
      @(posedge clock);
      csr_index <= CSR_LOW_THR;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_SPARE_2;
      csr_wdata <= DATA_W'($urandom);
      @(posedge clock);
      csr_index <= CSR_SPARE_3;
      csr_wdata <= DATA_W'($urandom);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // drive the sum past the upper 40-bit limit, then back into the sigmoid window
   task automatic saturation_run();
      put_weight(SLOT_W'(10), 16'h8000, 1'b0);
      put_weight(SLOT_W'(11), 16'h7FFF, 1'b0);
      repeat (SAT_CLIMB) put_value(SLOT_W'(10), 16'h8000, 1'b0);
      for (int i = 0; i < SAT_RETURN; i++) begin
         put_value(SLOT_W'(10), 16'h7FFF, i == SAT_RETURN - 1);
      end
   endtask

   initial begin : stimulus
      int start;
      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_index      <= CSR_HIGH_THR;
      csr_wdata      <= '0;
      req_ch.valid   <= 1'b0;
      req_ch.func    <= FUNC_WEIGHT;
      req_ch.slot    <= '0;
      req_ch.operand <= '0;
      req_ch.last    <= 1'b0;
      slot_written = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      put_weight(SLOT_W'(0), 16'h1000, 1'b0);
      put_weight(SLOT_W'(1), 16'h8000, 1'b0);
      put_weight(SLOT_W'(2), 16'h0000, 1'b0);
      put_weight(SLOT_W'(63), 16'h7FFF, 1'b0);
      // last on a weight request is ignored
      put_weight(SLOT_W'(5), 16'hFFFF, 1'b1);
      put_value(SLOT_W'(0), 16'h0000, 1'b1);
      put_value(SLOT_W'(1), 16'h8000, 1'b1);
      put_value(SLOT_W'(1), 16'h7FFF, 1'b1);
      // sum exactly +8
      put_value(SLOT_W'(0), 16'h4000, 1'b0);
      put_value(SLOT_W'(0), 16'h4000, 1'b1);
      // sum exactly -8
      put_value(SLOT_W'(0), 16'hC000, 1'b0);
      put_value(SLOT_W'(0), 16'hC000, 1'b1);
      // just below -8
      put_value(SLOT_W'(0), 16'hC000, 1'b0);
      put_value(SLOT_W'(0), 16'hC000, 1'b0);
      put_value(SLOT_W'(5), 16'h0001, 1'b1);
      // disconnected slot
      put_value(SLOT_W'(2), 16'h7FFF, 1'b1);
      put_value(SLOT_W'(63), 16'h8000, 1'b1);
      put_value(SLOT_W'(63), 16'h7FFF, 1'b1);
      put_value(SLOT_W'(0), 16'h0001, 1'b1);
      put_value(SLOT_W'(0), 16'hFFFF, 1'b1);

      for (int phase = 1; phase <= N_PHASES; phase++) begin
         case (phase)
            1:       write_thresholds(16'hFFFF, 16'h0000);
            2:       write_thresholds(16'h0000, 16'hFFFF);
            3:       write_thresholds(16'h0000, 16'h0000);
            4:       write_thresholds(DATA_W'($urandom), DATA_W'($urandom));
            5:       write_thresholds(16'h8000, 16'h8000);
            default: write_thresholds(16'd58982, 16'd6554);
         endcase
         if (phase == 2) begin
            hold_burst();
         end
         if (phase == 4) begin
            saturation_run();
         end
         start = accepted;
         while (accepted - start < RANDOM_PER_PHASE) begin
            if (phase == N_PHASES && accepted - start >= RANDOM_PER_PHASE - CALM_ITEMS) begin
               calm <= 1'b1;
            end
            run_evaluation();
         end
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### files.f
src/snm_pkg.sv
src/snm_req_if.sv
src/snm_rsp_if.sv
src/snm_weight_ram.sv
src/snm_mac.sv
src/snm_act.sv
src/sigmoid_neuron_mac.sv
bench/neuron_result_checker.sv
bench/testbench.sv
